// ----- rtl/uvst_pkg.sv -----
// Package with the sizes, field types and trigonometry tables of the UV sphere tessellator.
package uvst_pkg;

    localparam int STACKS       = 32;
    localparam int SECTORS      = 32;
    localparam int IDX_W        = 5;
    localparam int RING_W       = $clog2(STACKS + 1);
    localparam int SECT_W       = $clog2(SECTORS + 1);
    localparam int NORM_W       = 16;
    localparam int POS_W        = 17;
    localparam int RADIUS_W     = 16;
    localparam int CORNER_W     = 2;
    localparam int IN_DATA_W    = 16;
    localparam int OUT_FIELDS_W = CORNER_W + 3 * POS_W + 3 * NORM_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int CNT_W        = 3;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd256;
    localparam logic signed [NORM_W-1:0] ONE_Q14 = 16'sd16384;

    localparam logic [CORNER_W-1:0] CORNER_FIRST = 2'd0;
    localparam logic [CORNER_W-1:0] CORNER_MID   = 2'd1;
    localparam logic [CORNER_W-1:0] CORNER_LAST  = 2'd2;

    // Row class of the cell being expanded.
    typedef enum logic [1:0] {
        ROW_TOP = 2'd0,
        ROW_MID = 2'd1,
        ROW_BOT = 2'd2
    } row_kind_t;

    typedef logic signed [NORM_W-1:0] ring_tab_t [STACKS + 1];
    typedef logic signed [NORM_W-1:0] sect_tab_t [SECTORS + 1];

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned Q30_ONE     = 64'h4000_0000;
    localparam longint unsigned Taylor_div [8] = '{1, 6, 20, 42, 72, 110, 156, 210};

    // Quarter-wave sine in Q1.14 from a Q30 fraction of a quarter turn.
    function automatic logic signed [NORM_W-1:0] sin_quarter(input longint unsigned f);
        longint unsigned t;
        longint unsigned t2;
        longint unsigned term;
        longint acc;
        longint r;
        t    = (f * HALF_PI_Q30) >> 30;
        t2   = (t * t) >> 30;
        term = t;
        acc  = longint'(t);
        for (int k = 1; k <= 7; k++)
        begin
            term = (term * t2) >> 30;
            term = term / Taylor_div[k];
            if (k % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        r = (acc + 32768) >>> 16;
        if (r > 16384)
            r = 16384;
        return NORM_W'(r);
    endfunction

    function automatic logic signed [NORM_W-1:0] sin_turn(input logic [31:0] p);
        longint unsigned f;
        logic signed [NORM_W-1:0] v;
        f = longint'(p[29:0]);
        if (p[30])
            f = Q30_ONE - f;
        v = sin_quarter(f);
        return p[31] ? -v : v;
    endfunction

    function automatic logic signed [NORM_W-1:0] cos_turn(input logic [31:0] p);
        logic [31:0] q;
        q = p + 32'h4000_0000;
        return sin_turn(q);
    endfunction

    function automatic logic [31:0] ring_phase(input int r);
        longint unsigned num;
        num = longint'(r) << 31;
        return 32'(num / STACKS);
    endfunction

    function automatic logic [31:0] sect_phase(input int s);
        longint unsigned num;
        num = longint'(s) << 32;
        return 32'(num / SECTORS);
    endfunction

    // The poles get exact values so that one datapath serves every vertex.
    function automatic ring_tab_t ring_sin_table();
        ring_tab_t tab;
        for (int r = 0; r <= STACKS; r++)
        begin
            if (r == 0 || r == STACKS)
                tab[r] = '0;
            else
                tab[r] = sin_turn(ring_phase(r));
        end
        return tab;
    endfunction

    function automatic ring_tab_t ring_cos_table();
        ring_tab_t tab;
        for (int r = 0; r <= STACKS; r++)
        begin
            if (r == 0)
                tab[r] = ONE_Q14;
            else if (r == STACKS)
                tab[r] = -ONE_Q14;
            else
                tab[r] = cos_turn(ring_phase(r));
        end
        return tab;
    endfunction

    function automatic sect_tab_t sect_sin_table();
        sect_tab_t tab;
        for (int s = 0; s <= SECTORS; s++)
            tab[s] = sin_turn(sect_phase(s));
        return tab;
    endfunction

    function automatic sect_tab_t sect_cos_table();
        sect_tab_t tab;
        for (int s = 0; s <= SECTORS; s++)
            tab[s] = cos_turn(sect_phase(s));
        return tab;
    endfunction

    localparam ring_tab_t RING_SIN = ring_sin_table();
    localparam ring_tab_t RING_COS = ring_cos_table();
    localparam sect_tab_t SECT_SIN = sect_sin_table();
    localparam sect_tab_t SECT_COS = sect_cos_table();

    // Drops 14 fraction bits, rounding half away from zero.
    function automatic logic signed [19:0] rnd_q14(input logic signed [33:0] p);
        logic signed [33:0] sum;
        sum = p + (p[33] ? 34'sd8191 : 34'sd8192);
        return sum[33:14];
    endfunction

endpackage

// ----- rtl/uv_sphere_tessellator_unit.sv -----
// Top level of the UV sphere tessellator: cell expander and vertex pipeline.
//
//  Channel  | Direction | Signals                           | Content
//  ---------+-----------+-----------------------------------+-------------------------------
//  s_axis   | in        | tvalid tready tdata[15:0]         | one grid cell
//  m_axis   | out       | tvalid tready tdata[103:0] tlast  | one vertex per request
//  cfg      | in        | cfg_valid cfg_ready cfg_data[15:0]| radius, unsigned Q8.8
//
// A cell expands into three vertices on the top and bottom rows and six elsewhere, one
// vertex per cycle unless m_axis stalls the pipeline; the expander stage sets the vertex count.
// The first vertex of a cell passes the expander registers, then the lookup, normal and position stages.
// A new cell is taken in the same cycle as the final vertex of the previous one.
// Reset clears all valid bits and loads a radius of 1.0; cfg_ready is always high.
// When m_axis_tready is low while m_axis_tvalid is high, the whole pipeline holds its contents.
module uv_sphere_tessellator_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [4:0] stack_index, [9:5] sector_index, [15:10] zero
    input  logic [uvst_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [1:0] corner, [18:2] pos_x, [35:19] pos_y, [52:36] pos_z,
    // [68:53] norm_x, [84:69] norm_y, [100:85] norm_z, [103:101] zero
    output logic [uvst_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [uvst_pkg::RADIUS_W-1:0]    cfg_data
);

    localparam int RW = uvst_pkg::RING_W;
    localparam int SW = uvst_pkg::SECT_W;
    localparam int NW = uvst_pkg::NORM_W;
    localparam int PW = uvst_pkg::POS_W;

    logic [uvst_pkg::RADIUS_W-1:0] radius_reg;

    // Expander state.
    logic                         busy_reg;
    logic [uvst_pkg::IDX_W-1:0]   row_reg;
    logic [uvst_pkg::IDX_W-1:0]   col_reg;
    uvst_pkg::row_kind_t          kind_reg;
    logic [uvst_pkg::CNT_W-1:0]   cnt_reg;

    // Lookup stage.
    logic                         v1_reg;
    logic [uvst_pkg::CORNER_W-1:0] corner1_reg;
    logic                         last1_reg;
    logic signed [NW-1:0]         st1_reg, ct1_reg, sp1_reg, cp1_reg;

    // Normal stage.
    logic                         v2_reg;
    logic [uvst_pkg::CORNER_W-1:0] corner2_reg;
    logic                         last2_reg;
    logic signed [NW-1:0]         nx2_reg, ny2_reg, nz2_reg;

    // Output stage.
    logic                         v3_reg;
    logic [uvst_pkg::CORNER_W-1:0] corner3_reg;
    logic                         last3_reg;
    logic signed [PW-1:0]         px3_reg, py3_reg, pz3_reg;
    logic signed [NW-1:0]         nx3_reg, ny3_reg, nz3_reg;

    logic                         adv;
    logic                         in_fire;
    logic                         in_range;
    logic [uvst_pkg::IDX_W-1:0]   in_row;
    logic [uvst_pkg::IDX_W-1:0]   in_col;
    logic [RW-1:0]                d_ring;
    logic [SW-1:0]                d_sect;
    logic [uvst_pkg::CORNER_W-1:0] d_corner;
    logic                         d_last;
    logic [RW-1:0]                ring_cur;
    logic [RW-1:0]                ring_nxt;
    logic [SW-1:0]                sect_cur;
    logic [SW-1:0]                sect_nxt;
    logic signed [31:0]           prod_x, prod_z;
    logic signed [32:0]           prad_x, prad_y, prad_z;
    logic signed [19:0]           rnd_nx, rnd_nz, rnd_px, rnd_py, rnd_pz;
    logic signed [PW-1:0]         radius_s;

    assign adv       = !v3_reg || m_axis_tready;
    assign cfg_ready = 1'b1;
    assign in_row    = s_axis_tdata[uvst_pkg::IDX_W-1:0];
    assign in_col    = s_axis_tdata[2*uvst_pkg::IDX_W-1:uvst_pkg::IDX_W];
    assign in_range  = (int'(in_row) < uvst_pkg::STACKS) && (int'(in_col) < uvst_pkg::SECTORS);

    assign ring_cur = RW'(row_reg);
    assign ring_nxt = RW'(row_reg) + RW'(1);
    assign sect_cur = SW'(col_reg);
    assign sect_nxt = SW'(col_reg) + SW'(1);

    // Vertex descriptor for the current count of the cell being expanded.
    always_comb
    begin
        d_ring   = ring_cur;
        d_sect   = sect_cur;
        d_corner = uvst_pkg::CORNER_FIRST;
        d_last   = 1'b0;
        case (kind_reg)
            uvst_pkg::ROW_TOP:
            begin
                d_last = (cnt_reg == 3'd2);
                case (cnt_reg)
                    3'd0:
                    begin
                        d_ring   = '0;
                        d_sect   = '0;
                        d_corner = uvst_pkg::CORNER_FIRST;
                    end
                    3'd1:
                    begin
                        d_ring   = RW'(1);
                        d_sect   = sect_nxt;
                        d_corner = uvst_pkg::CORNER_MID;
                    end
                    default:
                    begin
                        d_ring   = RW'(1);
                        d_sect   = sect_cur;
                        d_corner = uvst_pkg::CORNER_LAST;
                    end
                endcase
            end
            uvst_pkg::ROW_BOT:
            begin
                d_last = (cnt_reg == 3'd2);
                case (cnt_reg)
                    3'd0:
                    begin
                        d_ring   = ring_cur;
                        d_sect   = sect_cur;
                        d_corner = uvst_pkg::CORNER_FIRST;
                    end
                    3'd1:
                    begin
                        d_ring   = RW'(uvst_pkg::STACKS);
                        d_sect   = '0;
                        d_corner = uvst_pkg::CORNER_MID;
                    end
                    default:
                    begin
                        d_ring   = ring_cur;
                        d_sect   = sect_nxt;
                        d_corner = uvst_pkg::CORNER_LAST;
                    end
                endcase
            end
            default:
            begin
                d_last = (cnt_reg == 3'd5);
                case (cnt_reg)
                    3'd0:
                    begin
                        d_ring   = ring_cur;
                        d_sect   = sect_nxt;
                        d_corner = uvst_pkg::CORNER_FIRST;
                    end
                    3'd1:
                    begin
                        d_ring   = ring_nxt;
                        d_sect   = sect_cur;
                        d_corner = uvst_pkg::CORNER_MID;
                    end
                    3'd2:
                    begin
                        d_ring   = ring_cur;
                        d_sect   = sect_cur;
                        d_corner = uvst_pkg::CORNER_LAST;
                    end
                    3'd3:
                    begin
                        d_ring   = ring_cur;
                        d_sect   = sect_nxt;
                        d_corner = uvst_pkg::CORNER_FIRST;
                    end
                    3'd4:
                    begin
                        d_ring   = ring_nxt;
                        d_sect   = sect_nxt;
                        d_corner = uvst_pkg::CORNER_MID;
                    end
                    default:
                    begin
                        d_ring   = ring_nxt;
                        d_sect   = sect_cur;
                        d_corner = uvst_pkg::CORNER_LAST;
                    end
                endcase
            end
        endcase
    end

    // A new cell enters when the pipeline advances and the expander is empty or hands out its final vertex.
    assign s_axis_tready = adv && (!busy_reg || d_last);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= uvst_pkg::RADIUS_RESET;
        else if (cfg_valid && cfg_ready)
            radius_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
        end
        else if (adv)
        begin
            if (in_fire)
            begin
                busy_reg <= in_range;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                busy_reg <= !d_last;
                cnt_reg  <= cnt_reg + 3'd1;
            end
            v1_reg <= busy_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            row_reg <= in_row;
            col_reg <= in_col;
            if (in_row == '0)
                kind_reg <= uvst_pkg::ROW_TOP;
            else if (int'(in_row) == uvst_pkg::STACKS - 1)
                kind_reg <= uvst_pkg::ROW_BOT;
            else
                kind_reg <= uvst_pkg::ROW_MID;
        end
    end

    // Normals: polar sine scales the azimuth cosine and sine.
    assign prod_x = st1_reg * cp1_reg;
    assign prod_z = st1_reg * sp1_reg;
    assign rnd_nx = uvst_pkg::rnd_q14(34'(prod_x));
    assign rnd_nz = uvst_pkg::rnd_q14(34'(prod_z));

    // Positions: radius times the quantized normal.
    assign radius_s = $signed({1'b0, radius_reg});
    assign prad_x   = radius_s * nx2_reg;
    assign prad_y   = radius_s * ny2_reg;
    assign prad_z   = radius_s * nz2_reg;
    assign rnd_px   = uvst_pkg::rnd_q14(34'(prad_x));
    assign rnd_py   = uvst_pkg::rnd_q14(34'(prad_y));
    assign rnd_pz   = uvst_pkg::rnd_q14(34'(prad_z));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            corner1_reg <= d_corner;
            last1_reg   <= d_last;
            st1_reg     <= uvst_pkg::RING_SIN[d_ring];
            ct1_reg     <= uvst_pkg::RING_COS[d_ring];
            sp1_reg     <= uvst_pkg::SECT_SIN[d_sect];
            cp1_reg     <= uvst_pkg::SECT_COS[d_sect];

            corner2_reg <= corner1_reg;
            last2_reg   <= last1_reg;
            nx2_reg     <= rnd_nx[NW-1:0];
            ny2_reg     <= ct1_reg;
            nz2_reg     <= rnd_nz[NW-1:0];

            corner3_reg <= corner2_reg;
            last3_reg   <= last2_reg;
            px3_reg     <= rnd_px[PW-1:0];
            py3_reg     <= rnd_py[PW-1:0];
            pz3_reg     <= rnd_pz[PW-1:0];
            nx3_reg     <= nx2_reg;
            ny3_reg     <= ny2_reg;
            nz3_reg     <= nz2_reg;
        end
    end

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tlast  = last3_reg;
    assign m_axis_tdata  = {
        (uvst_pkg::OUT_DATA_W - uvst_pkg::OUT_FIELDS_W)'(0),
        nz3_reg, ny3_reg, nx3_reg, pz3_reg, py3_reg, px3_reg, corner3_reg
    };

    // The final vertex of a cell always closes a triangle.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> corner3_reg == uvst_pkg::CORNER_LAST)
        else $error("final vertex of a cell is not the last corner");

    // The expander count stays within the vertex count of its row class.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (kind_reg == uvst_pkg::ROW_MID) ? (cnt_reg <= 3'd5) : (cnt_reg <= 3'd2))
        else $error("expander count out of range");

    // A cell is only taken over a busy expander on its final vertex.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && busy_reg |-> d_last)
        else $error("cell accepted while expander still has vertices");

    // The x and y normal components stay within the unit range.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (ny3_reg <= uvst_pkg::ONE_Q14) && (ny3_reg >= -uvst_pkg::ONE_Q14)
                       && (nx3_reg <= uvst_pkg::ONE_Q14) && (nx3_reg >= -uvst_pkg::ONE_Q14))
        else $error("normal component out of unit range");

    // A stalled output holds its vertex.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled vertex changed");

endmodule
